// ===== rtl/key_auto_repeat_engine_macros.svh =====
// Assertion macros shared by the key auto-repeat checker
`ifndef KEY_AUTO_REPEAT_ENGINE_MACROS_SVH
`define KEY_AUTO_REPEAT_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define KARE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key auto-repeat check failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define KARE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key auto-repeat check failed");

`endif

// ===== rtl/kare_pkg.sv =====
// Package: types and constants of the key auto-repeat engine
`timescale 1ns / 1ps
`default_nettype none

package kare_pkg;

    localparam int NUM_KEYS = 128;
    localparam int ADDR_W   = $clog2(NUM_KEYS);
    localparam int KEY_W    = 7;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;

    localparam logic [15:0] FIRST_DELAY_RST     = 16'd250;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd50;

    typedef enum logic [0:0] {
        REG_FIRST_DELAY     = 1'b0,
        REG_REPEAT_INTERVAL = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_REPEAT  = 2'd1,
        KIND_RELEASE = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic              repeating;
        logic [TIME_W-1:0] last_time;
        logic              was_pressed;
    } t_key_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_key_state        state;
    } t_store_wr;

endpackage

`default_nettype wire

// ===== rtl/kare_key_store.sv =====
// Per-key state memory with valid bits and write-to-read forwarding
`timescale 1ns / 1ps
`default_nettype none

module kare_key_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [kare_pkg::ADDR_W-1:0] i_rd_addr,
    output kare_pkg::t_key_state            o_rd_state,
    input  wire kare_pkg::t_store_wr        i_wr
);

    kare_pkg::t_key_state r_mem [kare_pkg::NUM_KEYS];
    logic [kare_pkg::NUM_KEYS-1:0] r_valid;

    kare_pkg::t_key_state r_mem_q;
    kare_pkg::t_key_state r_fwd_state;
    logic                 r_fwd;
    logic                 r_hit_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.state;
        end
        if (i_rd_en) begin
            r_mem_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fwd       <= 1'b0;
            r_hit_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_fwd       <= i_wr.en && (i_wr.addr == i_rd_addr);
                r_hit_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_state <= i_wr.state;
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_state = r_fwd_state;
        end else if (r_hit_valid) begin
            o_rd_state = r_mem_q;
        end else begin
            o_rd_state = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/key_auto_repeat_engine.sv =====
// Top level: key auto-repeat engine
// Usage:
//   Key samples enter on the s_axis channel, one per transaction; tdata holds
//   key index [6:0], pressed [7], now_ticks [39:8], ctrl [40], shift [41].
//   Events leave on the m_axis channel; tuser holds the kind (press, repeat,
//   release) and tdata holds key [6:0], ctrl [7], shift [8].
//   A sample yields zero or one event; idle keys and held keys not yet due
//   yield nothing.
//   Path: an accepted sample is registered into the modify stage, and its
//   event into the output register that drives the m_axis channel.
//   Throughput: one sample per cycle unless the receiver stalls; the per-key
//   memory is read on accept and written back from the modify stage as it
//   fires; a write to the key being read in the same cycle is forwarded.
//   Configuration: write the first-repeat delay (index 0) and repeat_interval
//   (index 1) through the cfg port while no sample is in flight.
//   Reset clears all per-key state at once via valid bits; no clearing pass.
//   s_axis tready stays low while reset is held.
//   When the receiver stalls, the event is held in the output register and
//   one further sample waits in the modify stage; s_axis tready then drops.
`timescale 1ns / 1ps
`default_nettype none

module key_auto_repeat_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // key_index[6:0], pressed[7], now_ticks[39:8], ctrl_held[40], shift_held[41]
    input  wire logic [47:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // event_key[6:0], event_ctrl[7], event_shift[8]
    output logic [15:0]      o_m_axis_tdata,
    // event_kind[1:0]
    output logic [1:0]       o_m_axis_tuser
);

    logic [kare_pkg::CFG_W-1:0] r_first_delay;
    logic [kare_pkg::CFG_W-1:0] r_repeat_interval;

    logic                        r_s1_valid;
    logic [kare_pkg::KEY_W-1:0]  r_s1_key;
    logic                        r_s1_down;
    logic [kare_pkg::TIME_W-1:0] r_s1_now;
    logic                        r_s1_ctrl;
    logic                        r_s1_shift;

    logic                   r_out_valid;
    kare_pkg::t_event_kind  r_out_kind;
    logic [kare_pkg::KEY_W-1:0] r_out_key;
    logic                   r_out_ctrl;
    logic                   r_out_shift;

    logic                        accept;
    logic                        s1_fire;
    logic                        in_range;
    logic                        emit;
    kare_pkg::t_event_kind       kind;
    kare_pkg::t_key_state        cur;
    kare_pkg::t_key_state        upd;
    kare_pkg::t_store_wr         wr;
    logic [kare_pkg::TIME_W-1:0] elapsed;
    logic [kare_pkg::CFG_W-1:0]  limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay     <= kare_pkg::FIRST_DELAY_RST;
            r_repeat_interval <= kare_pkg::REPEAT_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (kare_pkg::t_cfg_reg'(i_cfg_addr))
                kare_pkg::REG_FIRST_DELAY:     r_first_delay     <= i_cfg_wdata;
                kare_pkg::REG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s1_fire         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_s1_valid || s1_fire);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    kare_key_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (kare_pkg::ADDR_W'(i_s_axis_tdata[6:0])),
        .o_rd_state (cur),
        .i_wr       (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_key   <= i_s_axis_tdata[6:0];
            r_s1_down  <= i_s_axis_tdata[7];
            r_s1_now   <= i_s_axis_tdata[39:8];
            r_s1_ctrl  <= i_s_axis_tdata[40];
            r_s1_shift <= i_s_axis_tdata[41];
        end
    end

    // modify: decide the event and the new key state
    always_comb begin
        in_range = 32'(r_s1_key) < 32'(kare_pkg::NUM_KEYS);
        elapsed  = r_s1_now - cur.last_time;
        limit    = cur.repeating ? r_repeat_interval : r_first_delay;
        emit     = 1'b0;
        kind     = kare_pkg::KIND_PRESS;
        upd      = cur;
        if (r_s1_down && !cur.was_pressed) begin
            emit          = 1'b1;
            kind          = kare_pkg::KIND_PRESS;
            upd.last_time = r_s1_now;
            upd.repeating = 1'b0;
        end else if (r_s1_down) begin
            if (elapsed >= kare_pkg::TIME_W'(limit)) begin
                emit          = 1'b1;
                kind          = kare_pkg::KIND_REPEAT;
                upd.last_time = r_s1_now;
                upd.repeating = 1'b1;
            end
        end else if (cur.was_pressed) begin
            emit          = 1'b1;
            kind          = kare_pkg::KIND_RELEASE;
            upd.repeating = 1'b0;
        end
        upd.was_pressed = r_s1_down;
        emit            = emit && in_range;

        wr.en    = s1_fire && in_range;
        wr.addr  = kare_pkg::ADDR_W'(r_s1_key);
        wr.state = upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_kind  <= kind;
            r_out_key   <= r_s1_key;
            r_out_ctrl  <= r_s1_ctrl;
            r_out_shift <= r_s1_shift;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {7'b0, r_out_shift, r_out_ctrl, r_out_key};

endmodule

`default_nettype wire

// ===== rtl/kare_checker.sv =====
// Port-level checker for the key auto-repeat engine, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "key_auto_repeat_engine_macros.svh"

module kare_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    `KARE_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `KARE_ASSERT_NEXT(a_data_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata))
    `KARE_ASSERT_NEXT(a_user_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tuser))
    `KARE_ASSERT_NOW(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready)
    `KARE_ASSERT_NOW(a_kind_legal, o_m_axis_tvalid, o_m_axis_tuser <= kare_pkg::KIND_RELEASE)

endmodule

bind key_auto_repeat_engine kare_checker u_kare_checker (.*);

`default_nettype wire
